// ----- rtl/lrts_pkg.sv -----
// shared types and constants of the least-runtime task scheduler
`timescale 1ns / 1ps
package lrts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int KEY_BITS_DEF  = 48;

  localparam int CMD_BITS     = 3;
  localparam int SLOT_BITS    = 4;
  localparam int ELAPSED_BITS = 32;
  localparam int STATUS_BITS  = 3;

  typedef enum logic [1:0] {
    MODE_ABSENT = 2'd0,
    MODE_READY  = 2'd1,
    MODE_SUSP   = 2'd2,
    MODE_RUN    = 2'd3
  } mode_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ATTACH  = 3'd0,
    CMD_DETACH  = 3'd1,
    CMD_WAKE    = 3'd2,
    CMD_SUSPEND = 3'd3,
    CMD_PICK    = 3'd4,
    CMD_END     = 3'd5,
    CMD_QUERY   = 3'd6
  } cmd_t;

  typedef enum logic [STATUS_BITS-1:0] {
    STAT_OK       = 3'd0,
    STAT_ATTACHED = 3'd1,
    STAT_EMPTY    = 3'd2,
    STAT_NOTRUN   = 3'd3,
    STAT_ABSENT   = 3'd4
  } status_t;

  // write broadcast to the cell row, target slot and key data travel beside it
  typedef struct packed {
    logic  mode_we;
    mode_t mode;
    logic  key_we;
    logic  wake_we;
    logic  wake;
  } cell_wr_t;

  // summary handed from cell to cell, best key and slot travel beside it
  typedef struct packed {
    logic  found;
    logic  rdy_any;
    logic  rdy_multi;
    logic  susp_any;
    mode_t sel_mode;
    logic  run_wake;
  } scan_t;

endpackage

// ----- rtl/lrts_req_if.sv -----
// command channel: valid/ready with one command beat
`timescale 1ns / 1ps
interface lrts_req_if;
  import lrts_pkg::*;

  logic                    valid;
  logic                    ready;
  logic [CMD_BITS-1:0]     cmd;
  logic [SLOT_BITS-1:0]    task_slot;
  logic                    completed;
  logic [ELAPSED_BITS-1:0] elapsed_time;

  modport source (output valid, cmd, task_slot, completed, elapsed_time, input ready);
  modport sink   (input valid, cmd, task_slot, completed, elapsed_time, output ready);
endinterface

// ----- rtl/lrts_rsp_if.sv -----
// result channel: valid/ready with one result beat
`timescale 1ns / 1ps
interface lrts_rsp_if;
  import lrts_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [SLOT_BITS-1:0]   picked_slot;
  logic                   picked_valid;
  logic [STATUS_BITS-1:0] status;
  logic                   any_ready;
  logic                   any_suspended;
  logic                   slot_suspended;

  modport source (output valid, picked_slot, picked_valid, status, any_ready,
                  any_suspended, slot_suspended, input ready);
  modport sink   (input valid, picked_slot, picked_valid, status, any_ready,
                  any_suspended, slot_suspended, output ready);
endinterface

// ----- rtl/lrts_cell.sv -----
// one task slot: mode, wake mark and runtime key, plus one stage of the scan chain
`timescale 1ns / 1ps
module lrts_cell #(
  parameter int KEY_BITS = lrts_pkg::KEY_BITS_DEF,
  parameter int SLOT_W   = $clog2(lrts_pkg::MAX_TASKS_DEF)
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [SLOT_W-1:0]    idx,
  input  lrts_pkg::cell_wr_t   wr,
  input  logic [SLOT_W-1:0]    wr_slot,
  input  logic [KEY_BITS-1:0]  wr_key,
  input  logic [SLOT_W-1:0]    sel_slot,
  input  logic                 sel_en,
  input  logic [SLOT_W-1:0]    run_slot,
  input  lrts_pkg::scan_t      prev_flags,
  input  logic [KEY_BITS-1:0]  prev_key,
  input  logic [SLOT_W-1:0]    prev_slot,
  output lrts_pkg::scan_t      next_flags,
  output logic [KEY_BITS-1:0]  next_key,
  output logic [SLOT_W-1:0]    next_slot
);
  import lrts_pkg::*;

  mode_t               mode;
  logic                wake;
  logic [KEY_BITS-1:0] key;
  logic                wr_hit;
  logic                own_ready;
  logic                take_own;

  assign wr_hit    = (wr_slot == idx);
  assign own_ready = (mode == MODE_READY);
  // strict less keeps the lower slot on equal keys
  assign take_own  = own_ready && (!prev_flags.found || (key < prev_key));

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_ABSENT;
      wake <= 1'b0;
    end else if (wr_hit) begin
      if (wr.mode_we) mode <= wr.mode;
      if (wr.wake_we) wake <= wr.wake;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_hit && wr.key_we) key <= wr_key;
  end

  // chain stage, recomputed every cycle
  always_ff @(posedge clk) begin
    next_flags.found     <= prev_flags.found | own_ready;
    next_flags.rdy_any   <= prev_flags.rdy_any | own_ready;
    next_flags.rdy_multi <= prev_flags.rdy_multi | (prev_flags.rdy_any & own_ready);
    next_flags.susp_any  <= prev_flags.susp_any | (mode == MODE_SUSP);
    next_flags.sel_mode  <= (sel_en && (sel_slot == idx)) ? mode : prev_flags.sel_mode;
    next_flags.run_wake  <= (run_slot == idx) ? wake : prev_flags.run_wake;
    next_key             <= take_own ? key : prev_key;
    next_slot            <= take_own ? idx : prev_slot;
  end

endmodule

// ----- rtl/least_runtime_task_scheduler_core.sv -----
// least-runtime task scheduler: controller and row of slot cells
// the result beat follows the command beat through scan A, apply, scan B and finish
// one command at a time: a new command is taken only in idle, after the last one
//   has made two passes through the cell chain, one before and one after the update
// a finished result waits in the output register while the next command is taken
// reset (rst, synchronous): all slots absent, no wake marks, no task running
`timescale 1ns / 1ps
module least_runtime_task_scheduler_core #(
  parameter int MAX_TASKS = lrts_pkg::MAX_TASKS_DEF,
  parameter int KEY_BITS  = lrts_pkg::KEY_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  lrts_req_if.sink   req,
  lrts_rsp_if.source rsp
);
  import lrts_pkg::*;

  localparam int SLOT_W = $clog2(MAX_TASKS);
  // common width for converting between the 4-bit slot field and the cell index
  localparam int AW     = (SLOT_W > SLOT_BITS) ? SLOT_W : SLOT_BITS;
  localparam int SUM_W  = ((KEY_BITS > ELAPSED_BITS) ? KEY_BITS : ELAPSED_BITS) + 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_A,
    S_APPLY,
    S_SCAN_B,
    S_FINISH
  } state_t;

  state_t state;

  // latched command beat
  cmd_t                    cmd_q;
  logic [SLOT_W-1:0]       slot_q;
  logic                    inr_q;
  logic                    completed_q;
  logic [ELAPSED_BITS-1:0] elapsed_q;
  logic [SLOT_W-1:0]       cnt;

  // dispatch state
  logic [SLOT_W-1:0]   running_slot;
  logic [KEY_BITS-1:0] running_key;
  logic                running_valid;
  logic                suspend_mark;

  status_t status_q;

  // scan chain, entry 0 is the seed at the head
  scan_t               chain_flags [MAX_TASKS+1];
  logic [KEY_BITS-1:0] chain_key   [MAX_TASKS+1];
  logic [SLOT_W-1:0]   chain_slot  [MAX_TASKS+1];
  scan_t               tail;
  logic [KEY_BITS-1:0] tail_key;
  logic [SLOT_W-1:0]   tail_slot;

  // write broadcast
  cell_wr_t            wr;
  logic [SLOT_W-1:0]   wr_slot;
  logic [KEY_BITS-1:0] wr_key;

  logic [AW-1:0]       slot_wide;
  logic [AW-1:0]       pick_wide;
  logic                inr;
  logic [SUM_W-1:0]    key_sum;
  logic [KEY_BITS-1:0] key_sat;
  status_t             apply_status;
  logic                mark_set;
  logic                run_clear;
  logic                finish_fire;
  logic                pick_take;
  logic                markrun;
  logic                scan_last;

  assign req.ready = (state == S_IDLE);

  assign slot_wide = AW'(req.task_slot);
  assign inr       = (int'(req.task_slot) < MAX_TASKS);
  assign pick_wide = AW'(tail_slot);

  assign tail      = chain_flags[MAX_TASKS];
  assign tail_key  = chain_key[MAX_TASKS];
  assign tail_slot = chain_slot[MAX_TASKS];

  assign chain_flags[0] = '0;
  assign chain_key[0]   = '0;
  assign chain_slot[0]  = '0;

  // saturating key update for end of slice
  assign key_sum = SUM_W'(running_key) + SUM_W'(elapsed_q);
  assign key_sat = (|key_sum[SUM_W-1:KEY_BITS]) ? {KEY_BITS{1'b1}} : key_sum[KEY_BITS-1:0];

  assign scan_last   = (cnt == SLOT_W'(MAX_TASKS - 1));
  assign finish_fire = (state == S_FINISH) && (!rsp.valid || rsp.ready);
  assign pick_take   = finish_fire && (cmd_q == CMD_PICK) && tail.found;
  assign markrun     = running_valid && suspend_mark;

  // command decode: in S_APPLY the chain tail holds the state before the update,
  // in S_FINISH the state after it
  always_comb begin
    wr           = '0;
    wr_slot      = running_slot;
    wr_key       = '0;
    apply_status = STAT_OK;
    mark_set     = 1'b0;
    run_clear    = 1'b0;
    if (state == S_APPLY) begin
      case (cmd_q)
        CMD_ATTACH: begin
          if (!inr_q) begin
            apply_status = STAT_ABSENT;
          end else if (tail.sel_mode != MODE_ABSENT) begin
            apply_status = STAT_ATTACHED;
          end else begin
            wr.mode_we = 1'b1;
            wr.mode    = MODE_READY;
            wr.key_we  = 1'b1;
            wr.wake_we = 1'b1;
            wr.wake    = 1'b0;
            wr_slot    = slot_q;
          end
        end
        CMD_DETACH: begin
          if (tail.sel_mode == MODE_ABSENT) begin
            apply_status = STAT_ABSENT;
          end else if (tail.sel_mode == MODE_SUSP) begin
            wr.mode_we = 1'b1;
            wr.mode    = MODE_ABSENT;
            wr.wake_we = 1'b1;
            wr.wake    = 1'b0;
            wr_slot    = slot_q;
          end
        end
        CMD_WAKE: begin
          wr_slot = slot_q;
          if (tail.sel_mode == MODE_ABSENT) begin
            apply_status = STAT_ABSENT;
          end else if (tail.sel_mode == MODE_SUSP) begin
            wr.mode_we = 1'b1;
            wr.mode    = MODE_READY;
            wr.key_we  = 1'b1;
          end else begin
            wr.wake_we = 1'b1;
            wr.wake    = 1'b1;
          end
        end
        CMD_SUSPEND: begin
          if (!running_valid || !inr_q || (running_slot != slot_q)) begin
            apply_status = STAT_NOTRUN;
          end else if (tail.run_wake) begin
            // pending wake cancels the suspend
            wr.wake_we = 1'b1;
            wr.wake    = 1'b0;
          end else begin
            mark_set = 1'b1;
          end
        end
        CMD_PICK: begin
          // running task goes back to ready with its dispatch key
          if (running_valid) begin
            wr.mode_we = 1'b1;
            wr.mode    = MODE_READY;
            wr.key_we  = 1'b1;
            wr_key     = running_key;
            run_clear  = 1'b1;
          end
        end
        CMD_END: begin
          if (!running_valid) begin
            apply_status = STAT_NOTRUN;
          end else begin
            run_clear  = 1'b1;
            wr.mode_we = 1'b1;
            wr.wake_we = suspend_mark && tail.run_wake;
            wr.wake    = 1'b0;
            if (completed_q || (suspend_mark && !tail.run_wake)) begin
              wr.mode = MODE_SUSP;
            end else begin
              wr.mode   = MODE_READY;
              wr.key_we = 1'b1;
              wr_key    = key_sat;
            end
          end
        end
        default: begin
          // query, and the unused code behaves the same
          if (tail.sel_mode == MODE_ABSENT) apply_status = STAT_ABSENT;
        end
      endcase
    end else if (pick_take) begin
      wr.mode_we = 1'b1;
      wr.mode    = MODE_RUN;
      wr_slot    = tail_slot;
    end
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_TASKS; gi++) begin : g_cell
      lrts_cell #(
        .KEY_BITS (KEY_BITS),
        .SLOT_W   (SLOT_W)
      ) u_cell (
        .clk        (clk),
        .rst        (rst),
        .idx        (SLOT_W'(gi)),
        .wr         (wr),
        .wr_slot    (wr_slot),
        .wr_key     (wr_key),
        .sel_slot   (slot_q),
        .sel_en     (inr_q),
        .run_slot   (running_slot),
        .prev_flags (chain_flags[gi]),
        .prev_key   (chain_key[gi]),
        .prev_slot  (chain_slot[gi]),
        .next_flags (chain_flags[gi+1]),
        .next_key   (chain_key[gi+1]),
        .next_slot  (chain_slot[gi+1])
      );
    end
  endgenerate

  // sequencer, dispatch state and the result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      running_slot  <= '0;
      running_key   <= '0;
      running_valid <= 1'b0;
      suspend_mark  <= 1'b0;
      rsp.valid     <= 1'b0;
    end else begin
      // a new beat loaded in the same cycle keeps valid high
      if (rsp.valid && rsp.ready && !finish_fire) rsp.valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            cmd_q       <= cmd_t'(req.cmd);
            slot_q      <= slot_wide[SLOT_W-1:0];
            inr_q       <= inr;
            completed_q <= req.completed;
            elapsed_q   <= req.elapsed_time;
            cnt         <= '0;
            state       <= S_SCAN_A;
          end
        end
        S_SCAN_A: begin
          cnt <= cnt + 1'b1;
          if (scan_last) state <= S_APPLY;
        end
        S_APPLY: begin
          status_q <= apply_status;
          if (mark_set) suspend_mark <= 1'b1;
          if (run_clear) begin
            running_valid <= 1'b0;
            suspend_mark  <= 1'b0;
          end
          cnt   <= '0;
          state <= S_SCAN_B;
        end
        S_SCAN_B: begin
          cnt <= cnt + 1'b1;
          if (scan_last) state <= S_FINISH;
        end
        S_FINISH: begin
          if (finish_fire) begin
            rsp.valid          <= 1'b1;
            rsp.picked_valid   <= pick_take;
            rsp.picked_slot    <= pick_take ? pick_wide[SLOT_BITS-1:0] : '0;
            rsp.any_suspended  <= tail.susp_any | markrun;
            rsp.slot_suspended <= inr_q && ((tail.sel_mode == MODE_SUSP) ||
                                            (markrun && (running_slot == slot_q)));
            if (cmd_q == CMD_PICK) begin
              rsp.status    <= tail.found ? STAT_OK : STAT_EMPTY;
              rsp.any_ready <= tail.rdy_multi;
            end else begin
              rsp.status    <= status_q;
              rsp.any_ready <= tail.rdy_any;
            end
            if (pick_take) begin
              running_slot  <= tail_slot;
              running_key   <= tail_key;
              running_valid <= 1'b1;
              suspend_mark  <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // suspend mark only exists on a running task
  a_mark_needs_run: assert property (@(posedge clk) disable iff (rst)
    suspend_mark |-> running_valid)
    else $error("suspend mark without running task");

  // a dispatch result always reports ok
  a_pick_ok: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.picked_valid) |-> (rsp.status == STAT_OK))
    else $error("dispatch beat with error status");

  // a successful pick leaves a task running without suspend mark
  a_pick_runs: assert property (@(posedge clk) disable iff (rst)
    pick_take |=> (running_valid && !suspend_mark))
    else $error("pick did not dispatch");

  // result beats only come from the finish step
  a_rsp_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state == S_FINISH))
    else $error("result beat outside finish");

endmodule
